// File: sv/pqs_pkg.sv
// ----------------------------------------------------------------------------
// pqs_pkg: shared types and constants of the priority quantum scheduler
// Table geometry, request/status/register codes, controller states and the
// structs that travel along the row of job cells.
// ----------------------------------------------------------------------------
package pqs_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int LEVEL_COUNT = 3;
	localparam int LVL_W       = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
	localparam int ID_W        = 16;
	localparam int BURST_W     = 16;
	localparam int TIME_W      = 20;
	localparam int QNT_W       = 16;

	localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVEL_COUNT - 1);

	// request codes
	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_ROUND  = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_SLICE = 2'd0;
	localparam logic [1:0] STAT_DONE  = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// register indexes
	localparam logic [1:0] CFG_QHIGH = 2'd0;
	localparam logic [1:0] CFG_QMED  = 2'd1;
	localparam logic [1:0] CFG_QLOW  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FULL
	} pqs_state_t;

	// broadcast to every cell
	typedef struct packed {
		logic               clr;
		logic               wr;
		logic               run;
		logic [LVL_W-1:0]   lvl;
		logic [QNT_W-1:0]   quantum;
		logic [ID_W-1:0]    wr_id;
		logic [BURST_W-1:0] wr_burst;
		logic [LVL_W-1:0]   wr_lvl;
	} pqs_ctl_t;

	// handed from one cell to the next
	typedef struct packed {
		logic                   free;   // some earlier cell is unloaded
		logic                   found;  // some earlier cell claimed the slice
		logic [LEVEL_COUNT-1:0] work;   // per level: a loaded job with work left
		logic [ID_W-1:0]        id;
		logic [BURST_W-1:0]     run;
		logic                   fin;
	} pqs_link_t;

endpackage

// File: sv/pqs_cell.sv
// ----------------------------------------------------------------------------
// pqs_cell: one job slot of the scheduler table
// Holds id, remaining burst and level; claims the append slot or the slice
// of the visited level when no earlier cell has, and passes the link on.
// ----------------------------------------------------------------------------
module pqs_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  pqs_pkg::pqs_ctl_t   ctl,
	input  pqs_pkg::pqs_link_t  link_in,
	output pqs_pkg::pqs_link_t  link_out
);

	logic                               loaded_q;
	logic [pqs_pkg::ID_W-1:0]           id_q;
	logic [pqs_pkg::BURST_W-1:0]        rem_q;
	logic [pqs_pkg::LVL_W-1:0]          lvl_q;

	logic                               has_work;
	logic                               elig;
	logic                               pick;
	logic                               take_wr;
	logic [pqs_pkg::BURST_W-1:0]        run_len;

	// eligibility and slice length
	always_comb begin
		has_work = loaded_q && (rem_q != '0);
		elig     = has_work && (lvl_q == ctl.lvl);
		pick     = elig && !link_in.found;
		take_wr  = ctl.wr && !loaded_q && !link_in.free;
		run_len  = (rem_q > ctl.quantum) ? ctl.quantum : rem_q;
	end

	// link to the next cell
	always_comb begin
		link_out       = link_in;
		link_out.free  = link_in.free | !loaded_q;
		link_out.found = link_in.found | elig;
		for (int k = 0; k < pqs_pkg::LEVEL_COUNT; k++) begin
			if (int'(lvl_q) == k) begin
				link_out.work[k] = link_in.work[k] | has_work;
			end
		end
		if (pick) begin
			link_out.id  = id_q;
			link_out.run = run_len;
			link_out.fin = (rem_q <= ctl.quantum);
		end
	end

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
		end else if (ctl.clr) begin
			loaded_q <= 1'b0;
		end else if (take_wr) begin
			loaded_q <= 1'b1;
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (take_wr) begin
			id_q  <= ctl.wr_id;
			rem_q <= ctl.wr_burst;
			lvl_q <= ctl.wr_lvl;
		end else if (ctl.run && pick) begin
			rem_q <= rem_q - run_len;
		end
	end

endmodule

// File: sv/pqs_chain.sv
// ----------------------------------------------------------------------------
// pqs_chain: row of job cells
// Cells are linked first to last; the link leaving the last cell carries
// the table-full flag, the per-level work flags and the picked slice.
// ----------------------------------------------------------------------------
module pqs_chain (
	input  logic                clk,
	input  logic                arst_n,
	input  pqs_pkg::pqs_ctl_t   ctl,
	output pqs_pkg::pqs_link_t  link_end
);

	pqs_pkg::pqs_link_t link [0:pqs_pkg::TABLE_DEPTH];

	assign link[0] = '0;

	for (genvar i = 0; i < pqs_pkg::TABLE_DEPTH; i++) begin : g_cell
		pqs_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.link_in  (link[i]),
			.link_out (link[i+1])
		);
	end

	assign link_end = link[pqs_pkg::TABLE_DEPTH];

endmodule

// File: sv/priority_quantum_scheduler_core.sv
// ----------------------------------------------------------------------------
// priority_quantum_scheduler_core: multilevel priority round scheduler
// Job table held in a row of cells; a small controller visits the levels
// one per unstalled cycle and emits one slice beat per level with work.
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   input    | in_valid, in_stall, req fields   | in
//   result   | out_valid, out_stall, fields     | out
//   config   | cfg_we, cfg_index, cfg_data      | in
//
// A round is accepted, then the controller steps one level through the cell
// row per cycle while the result register is free, visiting up to
// LEVEL_COUNT levels. A full-table append answers with a full beat. Reset
// empties the table, zeroes time and loads default quanta. A stalled result
// holds its level step until the register frees.
// ----------------------------------------------------------------------------
module priority_quantum_scheduler_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// input channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         req_type,
	input  logic [pqs_pkg::ID_W-1:0]           job_id,
	input  logic [pqs_pkg::BURST_W-1:0]        burst_length,
	input  logic [1:0]                         job_level,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         status,
	output logic [pqs_pkg::ID_W-1:0]           slice_job_id,
	output logic [1:0]                         slice_level,
	output logic [pqs_pkg::TIME_W-1:0]         slice_start,
	output logic [pqs_pkg::BURST_W-1:0]        slice_length,
	output logic                               job_finished,
	output logic                               last_of_round,
	// configuration
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [pqs_pkg::QNT_W-1:0]          cfg_data
);

	pqs_pkg::pqs_state_t               state_q, state_d;
	logic [pqs_pkg::LVL_W-1:0]         lvl_q;
	logic [pqs_pkg::TIME_W-1:0]        time_q;
	logic [pqs_pkg::QNT_W-1:0]         qhigh_q, qmed_q, qlow_q;

	logic                              out_valid_q;
	logic [1:0]                        status_q;
	logic [pqs_pkg::ID_W-1:0]          id_q;
	logic [1:0]                        level_q;
	logic [pqs_pkg::TIME_W-1:0]        start_q;
	logic [pqs_pkg::BURST_W-1:0]       length_q;
	logic                              fin_q;
	logic                              last_q;

	pqs_pkg::pqs_ctl_t                 ctl;
	pqs_pkg::pqs_link_t                link_end;

	logic                              accept;
	logic                              slot_free;
	logic                              work_above;
	logic [pqs_pkg::QNT_W-1:0]         quantum;
	logic [pqs_pkg::LVL_W-1:0]         wr_lvl;
	logic                              emit;
	logic [1:0]                        emit_status;
	logic                              emit_slice;
	logic                              emit_last;
	logic                              round_end;

	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != pqs_pkg::S_IDLE);

	// quantum of the visited level, zero acts as one
	always_comb begin
		if (lvl_q == pqs_pkg::LVL_W'(0)) begin
			quantum = qhigh_q;
		end else if (lvl_q == pqs_pkg::LVL_W'(1)) begin
			quantum = qmed_q;
		end else begin
			quantum = qlow_q;
		end
		if (quantum == '0) begin
			quantum = pqs_pkg::QNT_W'(1);
		end
	end

	// saturate appended level
	always_comb begin
		if (int'(job_level) > pqs_pkg::LEVEL_COUNT - 1) begin
			wr_lvl = pqs_pkg::LVL_LAST;
		end else begin
			wr_lvl = pqs_pkg::LVL_W'(job_level);
		end
	end

	// work left at levels after the visited one
	always_comb begin
		work_above = 1'b0;
		for (int k = 0; k < pqs_pkg::LEVEL_COUNT; k++) begin
			if (k > int'(lvl_q)) begin
				work_above = work_above | link_end.work[k];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pqs_pkg::S_IDLE: begin
				if (accept && req_type == pqs_pkg::REQ_ROUND) begin
					state_d = pqs_pkg::S_RUN;
				end else if (accept && req_type == pqs_pkg::REQ_APPEND && !link_end.free) begin
					state_d = pqs_pkg::S_FULL;
				end
			end
			pqs_pkg::S_RUN: begin
				if (round_end) begin
					state_d = pqs_pkg::S_IDLE;
				end
			end
			pqs_pkg::S_FULL: begin
				if (slot_free) begin
					state_d = pqs_pkg::S_IDLE;
				end
			end
			default: state_d = pqs_pkg::S_IDLE;
		endcase
	end

	// controller outputs: cell commands and result beats
	always_comb begin
		ctl          = '0;
		ctl.lvl      = lvl_q;
		ctl.quantum  = quantum;
		ctl.wr_id    = job_id;
		ctl.wr_burst = burst_length;
		ctl.wr_lvl   = wr_lvl;
		emit         = 1'b0;
		emit_status  = pqs_pkg::STAT_SLICE;
		emit_slice   = 1'b0;
		emit_last    = 1'b0;
		round_end    = 1'b0;
		case (state_q)
			pqs_pkg::S_IDLE: begin
				ctl.clr = accept && (req_type == pqs_pkg::REQ_CLEAR);
				ctl.wr  = accept && (req_type == pqs_pkg::REQ_APPEND);
			end
			pqs_pkg::S_RUN: begin
				if (slot_free) begin
					ctl.run = 1'b1;
					if (link_end.found) begin
						emit       = 1'b1;
						emit_slice = 1'b1;
						emit_last  = !work_above;
					end else if (lvl_q == '0 && link_end.work == '0) begin
						emit        = 1'b1;
						emit_status = pqs_pkg::STAT_DONE;
						emit_last   = 1'b1;
					end
					round_end = (emit && emit_last) || (lvl_q == pqs_pkg::LVL_LAST);
				end
			end
			pqs_pkg::S_FULL: begin
				if (slot_free) begin
					emit        = 1'b1;
					emit_status = pqs_pkg::STAT_FULL;
					emit_last   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control registers: state, level step, time, quanta
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pqs_pkg::S_IDLE;
			lvl_q   <= '0;
			time_q  <= '0;
			qhigh_q <= pqs_pkg::QNT_W'(10);
			qmed_q  <= pqs_pkg::QNT_W'(5);
			qlow_q  <= pqs_pkg::QNT_W'(2);
		end else begin
			state_q <= state_d;
			if (state_q == pqs_pkg::S_IDLE) begin
				lvl_q <= '0;
			end else if (state_q == pqs_pkg::S_RUN && slot_free && !round_end) begin
				lvl_q <= lvl_q + pqs_pkg::LVL_W'(1);
			end
			if (ctl.clr) begin
				time_q <= '0;
			end else if (emit_slice) begin
				time_q <= time_q + pqs_pkg::TIME_W'(link_end.run);
			end
			if (cfg_we) begin
				case (cfg_index)
					pqs_pkg::CFG_QHIGH: qhigh_q <= cfg_data;
					pqs_pkg::CFG_QMED:  qmed_q  <= cfg_data;
					pqs_pkg::CFG_QLOW:  qlow_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= emit_status;
			last_q   <= emit_last;
			if (emit_slice) begin
				id_q     <= link_end.id;
				level_q  <= 2'(lvl_q);
				start_q  <= time_q;
				length_q <= link_end.run;
				fin_q    <= link_end.fin;
			end else begin
				id_q     <= '0;
				level_q  <= '0;
				start_q  <= '0;
				length_q <= '0;
				fin_q    <= 1'b0;
			end
		end
	end

	pqs_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.link_end (link_end)
	);

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slice_job_id  = id_q;
	assign slice_level   = level_q;
	assign slice_start   = start_q;
	assign slice_length  = length_q;
	assign job_finished  = fin_q;
	assign last_of_round = last_q;

endmodule
